FILE: hw/rtl/lpm_pkg.sv
// Shared types, codes and constants of the longest-prefix-match table.
`timescale 1ns / 1ps
package lpm_pkg;

    localparam int ENTRIES_DEF   = 64;
    localparam int PEER_BITS_DEF = 8;

    localparam int OP_W       = 2;
    localparam int ADDR_W     = 64;
    localparam int LEN_W      = 8;
    localparam int PEER_ID_W  = 8;
    localparam int STATUS_W   = 2;
    localparam int PREFIX_W   = 2 * ADDR_W;
    localparam int V4_ADDR_W  = 32;

    localparam logic [LEN_W-1:0] V4_MAX_LEN = LEN_W'(32);
    localparam logic [LEN_W-1:0] V6_MAX_LEN = LEN_W'(128);

    localparam int S_DATA_W = 2 * ADDR_W + LEN_W + PEER_ID_W;
    localparam int S_USER_W = OP_W + 1;
    localparam int M_DATA_W = PEER_ID_W;
    localparam int M_USER_W = STATUS_W + 1;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_TOO_LONG = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr;     // write an empty row at the sweep index
        logic load;    // take the input beat and restart the sweep
        logic rd;      // read the row at the sweep index
        logic finish;  // commit an insert and load the result register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;      // sweep index is at the last row
        logic out_free;  // result register can take a new beat
    } sts_t;

    // Network mask for a prefix length within the family's limit.
    function automatic logic [PREFIX_W-1:0] prefix_mask(input logic v6,
                                                        input logic [LEN_W-1:0] len);
        logic [V4_ADDR_W-1:0] m4;
        logic [PREFIX_W-1:0]  m6;
        m4 = ~({V4_ADDR_W{1'b1}} >> len);
        m6 = ~({PREFIX_W{1'b1}} >> len);
        if (v6) begin
            return m6;
        end
        return {{(PREFIX_W - V4_ADDR_W){1'b0}}, m4};
    endfunction

endpackage

FILE: hw/rtl/lpm_ctrl.sv
// Controller state machine of the longest-prefix-match table.
`timescale 1ns / 1ps
module lpm_ctrl
    import lpm_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr = 1'b1;
                if (sts.last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.rd = 1'b1;
                if (sts.last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // The last row read is being evaluated in this cycle.
                state_next = S_DONE;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

FILE: hw/rtl/lpm_datapath.sv
// Datapath of the longest-prefix-match table: entry memory, sweep and result register.
`timescale 1ns / 1ps
module lpm_datapath
    import lpm_pkg::*;
#(
    parameter int ENTRIES   = ENTRIES_DEF,
    parameter int PEER_BITS = PEER_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    input  op_t                  in_op,
    input  logic                 in_is_v6,
    input  logic [ADDR_W-1:0]    in_addr_hi,
    input  logic [ADDR_W-1:0]    in_addr_lo,
    input  logic [LEN_W-1:0]     in_prefix_len,
    input  logic [PEER_ID_W-1:0] in_peer_id,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output status_t              out_status,
    output logic                 out_found,
    output logic [PEER_ID_W-1:0] out_peer
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef struct packed {
        logic                 valid;
        logic                 is_v6;
        logic [PREFIX_W-1:0]  prefix;
        logic [LEN_W-1:0]     len;
        logic [PEER_BITS-1:0] peer;
    } row_t;

    row_t mem [ENTRIES];

    // Sweep control.
    logic [AW-1:0] cnt_reg;
    logic          rd_vld_reg;
    logic [AW-1:0] rd_idx_reg;
    row_t          row_reg;

    // Operation taken from the input beat.
    op_t                  op_reg;
    logic                 v6_reg;
    logic [PREFIX_W-1:0]  q_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [PEER_BITS-1:0] peer_reg;
    logic                 bad_reg;

    // Sweep results.
    logic                 hit_reg;
    logic [AW-1:0]        hit_idx_reg;
    logic                 free_reg;
    logic [AW-1:0]        free_idx_reg;
    logic                 found_reg;
    logic [LEN_W-1:0]     best_len_reg;
    logic [PEER_BITS-1:0] best_peer_reg;

    // Result register.
    logic                 m_valid_reg;
    status_t              status_reg;
    logic                 found_out_reg;
    logic [PEER_ID_W-1:0] peer_out_reg;

    logic [PEER_BITS-1:0] peer_in;
    logic [PEER_ID_W-1:0] best_peer_w;
    logic [PREFIX_W-1:0]  q_in;
    logic                 bad_in;
    logic                 fam_eq;
    logic                 ins_eq;
    logic                 lkp_match;
    logic                 rm_match;
    logic                 ins_commit;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    row_t                 wr_data;
    row_t                 new_row;

    // Peer ids keep only the low PEER_BITS bits of the port field.
    genvar g;
    for (g = 0; g < PEER_BITS; g++) begin : g_peer_in
        if (g < PEER_ID_W) begin : g_bit
            assign peer_in[g] = in_peer_id[g];
        end else begin : g_zero
            assign peer_in[g] = 1'b0;
        end
    end
    for (g = 0; g < PEER_ID_W; g++) begin : g_peer_out
        if (g < PEER_BITS) begin : g_bit
            assign best_peer_w[g] = best_peer_reg[g];
        end else begin : g_zero
            assign best_peer_w[g] = 1'b0;
        end
    end

    always_comb begin
        if (in_is_v6) begin
            q_in   = {in_addr_hi, in_addr_lo};
            bad_in = (in_prefix_len > V6_MAX_LEN);
        end else begin
            q_in   = {{(PREFIX_W - V4_ADDR_W){1'b0}}, in_addr_lo[V4_ADDR_W-1:0]};
            bad_in = (in_prefix_len > V4_MAX_LEN);
        end
        // An insert stores only the network part of the address.
        if (in_op == OP_INSERT) begin
            q_in = q_in & prefix_mask(in_is_v6, in_prefix_len);
        end
    end

    assign fam_eq    = row_reg.valid && (row_reg.is_v6 == v6_reg);
    assign ins_eq    = fam_eq && (row_reg.len == len_reg) && (row_reg.prefix == q_reg);
    assign lkp_match = fam_eq && (row_reg.peer != '0) &&
                       ((q_reg & prefix_mask(row_reg.is_v6, row_reg.len)) == row_reg.prefix);
    assign rm_match  = row_reg.valid && (row_reg.peer == peer_reg);

    assign ins_commit = cmd.finish && (op_reg == OP_INSERT) && !bad_reg &&
                        (hit_reg || free_reg);

    always_comb begin
        new_row.valid  = 1'b1;
        new_row.is_v6  = v6_reg;
        new_row.prefix = q_reg;
        new_row.len    = len_reg;
        new_row.peer   = peer_reg;

        wr_en   = 1'b0;
        wr_addr = cnt_reg;
        wr_data = '0;
        if (cmd.clr) begin
            wr_en = 1'b1;
        end else if (rd_vld_reg && (op_reg == OP_REMOVE) && rm_match) begin
            wr_en         = 1'b1;
            wr_addr       = rd_idx_reg;
            wr_data       = row_reg;
            wr_data.valid = 1'b0;
        end else if (ins_commit) begin
            // A hit rewrites the same prefix with the new peer.
            wr_en   = 1'b1;
            wr_addr = hit_reg ? hit_idx_reg : free_idx_reg;
            wr_data = new_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd) begin
            row_reg <= mem[cnt_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.rd;
            if (cmd.load) begin
                cnt_reg <= '0;
            end else if (cmd.clr || cmd.rd) begin
                cnt_reg <= cnt_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= cnt_reg;
        if (cmd.load) begin
            op_reg    <= in_op;
            v6_reg    <= in_is_v6;
            q_reg     <= q_in;
            len_reg   <= in_prefix_len;
            peer_reg  <= peer_in;
            bad_reg   <= (in_op == OP_INSERT) && bad_in;
            hit_reg   <= 1'b0;
            free_reg  <= 1'b0;
            found_reg <= 1'b0;
        end else if (rd_vld_reg) begin
            if (row_reg.valid) begin
                if (!hit_reg && ins_eq) begin
                    hit_reg     <= 1'b1;
                    hit_idx_reg <= rd_idx_reg;
                end
            end else if (!free_reg) begin
                free_reg     <= 1'b1;
                free_idx_reg <= rd_idx_reg;
            end
            if (lkp_match && (!found_reg || (row_reg.len > best_len_reg))) begin
                found_reg     <= 1'b1;
                best_len_reg  <= row_reg.len;
                best_peer_reg <= row_reg.peer;
            end
        end
    end

    // Result register: holds one beat so the next item can be taken meanwhile.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            status_reg    <= ST_OK;
            found_out_reg <= 1'b0;
            peer_out_reg  <= '0;
            case (op_reg)
                OP_INSERT: begin
                    if (bad_reg) begin
                        status_reg <= ST_TOO_LONG;
                    end else if (!hit_reg && !free_reg) begin
                        status_reg <= ST_FULL;
                    end
                end
                OP_LOOKUP: begin
                    if (found_reg) begin
                        found_out_reg <= 1'b1;
                        peer_out_reg  <= best_peer_w;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign sts.last     = (cnt_reg == AW'(ENTRIES - 1));
    assign sts.out_free = !m_valid_reg || m_tready;

    assign m_tvalid   = m_valid_reg;
    assign out_status = status_reg;
    assign out_found  = found_out_reg;
    assign out_peer   = peer_out_reg;

endmodule

FILE: hw/rtl/longest_prefix_match_table.sv
// Top level of the longest-prefix-match routing table.
`timescale 1ns / 1ps
// IPv4 and IPv6 prefixes share one table of ENTRIES rows held in a single memory;
// each row maps a prefix to a peer id. Every operation (insert, lookup, remove
// of a peer) sweeps the whole memory through its one read port, one row per
// cycle: the beat is taken, the ENTRIES rows are read, the last row is
// evaluated, then an insert is committed and the result register is loaded
// once it can take a beat. One item is in work at a time; a finished result
// waits in its own register, so the next beat is taken while it is still
// pending. After reset the memory is cleared one row per cycle, and no input
// beat is taken until that pass ends. Lookups ignore rows with peer zero; a full
// table answers an insert of a new prefix with the table-full status.
module longest_prefix_match_table
    import lpm_pkg::*;
#(
    parameter int ENTRIES   = ENTRIES_DEF,
    parameter int PEER_BITS = PEER_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // addr_hi, addr_lo, prefix_len, peer_id
    input  logic [S_USER_W-1:0] s_tuser,  // op, is_v6
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,  // peer_out
    output logic [M_USER_W-1:0] m_tuser   // status, found
);

    cmd_t    cmd;
    sts_t    sts;
    status_t out_status;
    logic    out_found;

    lpm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lpm_datapath #(
        .ENTRIES   (ENTRIES),
        .PEER_BITS (PEER_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .in_op         (op_t'(s_tuser[OP_W-1:0])),
        .in_is_v6      (s_tuser[OP_W]),
        .in_addr_hi    (s_tdata[ADDR_W-1:0]),
        .in_addr_lo    (s_tdata[2*ADDR_W-1:ADDR_W]),
        .in_prefix_len (s_tdata[2*ADDR_W+LEN_W-1:2*ADDR_W]),
        .in_peer_id    (s_tdata[S_DATA_W-1:2*ADDR_W+LEN_W]),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .out_status    (out_status),
        .out_found     (out_found),
        .out_peer      (m_tdata)
    );

    assign m_tuser = {out_found, out_status};

endmodule

FILE: tb/sv/longest_prefix_match_table_test.sv
// Self-checking testbench for the longest-prefix-match routing table.
`timescale 1ns / 1ps
module longest_prefix_match_table_test;
    import lpm_pkg::*;

    localparam int ROWS = 64;

    typedef struct {
        status_t               status;
        bit                    found;
        logic [PEER_ID_W-1:0]  peer;
    } route_answer_t;

    // Keeps a shadow routing table and the answers still owed by the block.
    class route_table_checker;
        bit                    row_valid [ROWS];
        bit                    row_v6 [ROWS];
        logic [PREFIX_W-1:0]   row_prefix [ROWS];
        logic [LEN_W-1:0]      row_len [ROWS];
        logic [PEER_ID_W-1:0]  row_peer [ROWS];
        route_answer_t         owed_answers[$];
        int errors;
        int checked;
        int stored;
        int too_long;
        int full;
        int lookups;
        int hits;
        int removals;

        function new();
            foreach (row_valid[i]) row_valid[i] = 1'b0;
            errors = 0;
            checked = 0;
            stored = 0;
            too_long = 0;
            full = 0;
            lookups = 0;
            hits = 0;
            removals = 0;
        endfunction

        // Network bits of a prefix of the given length; IPv4 sits in the low 32 bits.
        static function logic [PREFIX_W-1:0] net_mask(bit v6, int len);
            logic [PREFIX_W-1:0] m;
            if (len == 0) begin
                m = '0;
            end else if (v6) begin
                m = {PREFIX_W{1'b1}} << (PREFIX_W - len);
            end else begin
                m = {{(PREFIX_W - V4_ADDR_W){1'b0}}, 32'hFFFF_FFFF << (V4_ADDR_W - len)};
            end
            return m;
        endfunction

        function void apply_request(op_t op, bit v6, logic [ADDR_W-1:0] hi,
                                    logic [ADDR_W-1:0] lo, logic [LEN_W-1:0] len,
                                    logic [PEER_ID_W-1:0] peer);
            logic [PREFIX_W-1:0] addr;
            route_answer_t ans;
            int hit;
            int free_row;
            int best;
            addr = v6 ? {hi, lo} : {{(PREFIX_W - V4_ADDR_W){1'b0}}, lo[V4_ADDR_W-1:0]};
            ans.status = ST_OK;
            ans.found = 1'b0;
            ans.peer = '0;
            hit = -1;
            free_row = -1;
            best = 0;
            case (op)
                OP_INSERT: begin
                    if (len > (v6 ? V6_MAX_LEN : V4_MAX_LEN)) begin
                        ans.status = ST_TOO_LONG;
                        too_long++;
                    end else begin
                        addr &= net_mask(v6, int'(len));
                        for (int i = 0; i < ROWS; i++) begin
                            if (row_valid[i]) begin
                                if (hit < 0 && row_v6[i] == v6 && row_len[i] == len &&
                                    row_prefix[i] == addr) hit = i;
                            end else if (free_row < 0) begin
                                free_row = i;
                            end
                        end
                        if (hit >= 0) begin
                            row_peer[hit] = peer;
                            stored++;
                        end else if (free_row >= 0) begin
                            row_valid[free_row] = 1'b1;
                            row_v6[free_row] = v6;
                            row_prefix[free_row] = addr;
                            row_len[free_row] = len;
                            row_peer[free_row] = peer;
                            stored++;
                        end else begin
                            ans.status = ST_FULL;
                            full++;
                        end
                    end
                end
                OP_LOOKUP: begin
                    lookups++;
                    for (int i = 0; i < ROWS; i++) begin
                        if (row_valid[i] && row_v6[i] == v6 && row_peer[i] != 0 &&
                            (addr & net_mask(v6, int'(row_len[i]))) == row_prefix[i]) begin
                            if (!ans.found || int'(row_len[i]) > best) begin
                                ans.found = 1'b1;
                                best = int'(row_len[i]);
                                ans.peer = row_peer[i];
                            end
                        end
                    end
                    if (ans.found) hits++;
                end
                OP_REMOVE: begin
                    removals++;
                    for (int i = 0; i < ROWS; i++) begin
                        if (row_valid[i] && row_peer[i] == peer) row_valid[i] = 1'b0;
                    end
                end
                default: begin
                end
            endcase
            owed_answers.push_back(ans);
        endfunction

        function void check_answer(status_t status, bit found, logic [PEER_ID_W-1:0] peer);
            route_answer_t want;
            checked++;
            if (owed_answers.size() == 0) begin
                $display("%0t: result beat with no answer owed (status %0d found %0d peer %0d)",
                         $time, status, found, peer);
                errors++;
                return;
            end
            want = owed_answers.pop_front();
            if (want.status !== status) begin
                $display("%0t: status expected %0d, got %0d", $time, want.status, status);
                errors++;
            end
            if (want.found !== found) begin
                $display("%0t: found expected %0d, got %0d", $time, want.found, found);
                errors++;
            end
            if (want.peer !== peer) begin
                $display("%0t: peer expected %0d, got %0d", $time, want.peer, peer);
                errors++;
            end
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [S_USER_W-1:0] s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [M_USER_W-1:0] m_tuser;

    route_table_checker   routes;
    logic [V4_ADDR_W-1:0] v4_nets [8];
    logic [PREFIX_W-1:0]  v6_nets [8];
    bit                   sender_steady = 1'b0;

    longest_prefix_match_table u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #8_000_000;
        $display("longest_prefix_match_table regression: fail");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 16);
        return $urandom_range(40, 150);
    endfunction

    task automatic offer(input op_t op, input bit v6, input logic [ADDR_W-1:0] hi,
                         input logic [ADDR_W-1:0] lo, input logic [LEN_W-1:0] len,
                         input logic [PEER_ID_W-1:0] peer);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= {peer, len, lo, hi};
        s_tuser <= {v6, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        routes.apply_request(op, v6, hi, lo, len, peer);
        gap = sender_steady ? 0 : random_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic random_request(input bit late_phase);
        int r;
        int k;
        int keep;
        int max_len;
        op_t op;
        bit v6;
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W-1:0] lo;
        logic [LEN_W-1:0] len;
        logic [PEER_ID_W-1:0] peer;
        logic [PREFIX_W-1:0] base;
        logic [PREFIX_W-1:0] m;
        logic [PREFIX_W-1:0] mixed;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            op = op_t'($urandom_range(0, 3));
            v6 = 1'($urandom_range(0, 1));
            hi = {$urandom, $urandom};
            lo = {$urandom, $urandom};
            len = LEN_W'($urandom_range(0, 255));
            peer = PEER_ID_W'($urandom_range(0, 255));
        end else begin
            v6 = 1'($urandom_range(0, 1));
            k = $urandom_range(0, 7);
            base = v6 ? v6_nets[k] : {{(PREFIX_W - V4_ADDR_W){1'b0}}, v4_nets[k]};
            r = $urandom_range(0, 99);
            // Early on the table is filled until it overflows; later removals thin it out.
            if (!late_phase) begin
                op = (r < 55) ? OP_INSERT : (r < 95) ? OP_LOOKUP : (r < 98) ? OP_REMOVE : OP_NONE;
            end else begin
                op = (r < 35) ? OP_INSERT : (r < 80) ? OP_LOOKUP : (r < 95) ? OP_REMOVE : OP_NONE;
            end
            peer = PEER_ID_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                          : $urandom_range(0, 7));
            max_len = v6 ? 128 : 32;
            len = LEN_W'(($urandom_range(0, 19) == 0) ? $urandom_range(max_len + 1, 255)
                                                      : $urandom_range(0, max_len));
            keep = (op == OP_INSERT && $urandom_range(0, 2) != 0) ? max_len
                                                                  : $urandom_range(0, max_len);
            m = route_table_checker::net_mask(v6, keep);
            mixed = (base & m) | ({$urandom, $urandom, $urandom, $urandom} & ~m);
            hi = v6 ? mixed[PREFIX_W-1:ADDR_W] : {$urandom, $urandom};
            lo = v6 ? mixed[ADDR_W-1:0] : {$urandom, mixed[V4_ADDR_W-1:0]};
        end
        offer(op, v6, hi, lo, len, peer);
    endtask

    // Results are checked the cycle they are taken.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            routes.check_answer(status_t'(m_tuser[STATUS_W-1:0]), m_tuser[STATUS_W], m_tdata);
        end
    end

    // Receiver: random stalls, plus one long hold that backs the block up into its input.
    initial begin
        int gap;
        bit held;
        held = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held && routes.checked >= 60) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (600) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
            gap = random_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    initial begin
        logic [ADDR_W-1:0] ones;
        ones = '1;
        routes = new();
        for (int k = 0; k < 8; k++) begin
            v4_nets[k] = (k < 4) ? {8'd10, 24'($urandom)} : $urandom;
            v6_nets[k] = (k < 4) ? {32'h2001_0db8, $urandom, $urandom, $urandom}
                                 : {$urandom, $urandom, $urandom, $urandom};
        end
        while (!aresetn) @(posedge aclk);

        // IPv4: a /8, a default route and a host route, then lengths past the limit.
        offer(OP_INSERT, 1'b0, '0, 64'h0000_0000_0a00_0000, 8'd8, 8'd1);
        offer(OP_INSERT, 1'b0, '0, 64'h0000_0000_0000_0000, 8'd0, 8'd2);
        offer(OP_INSERT, 1'b0, '0, 64'h0000_0000_0a01_0203, 8'd32, 8'd255);
        offer(OP_INSERT, 1'b0, '0, 64'h0000_0000_0a01_0203, 8'd33, 8'd3);
        offer(OP_INSERT, 1'b0, ones, ones, 8'd255, 8'd3);
        // The upper address bits are don't-care for IPv4.
        offer(OP_LOOKUP, 1'b0, ones, 64'hFFFF_FFFF_0a01_0203, 8'd0, 8'd0);
        offer(OP_LOOKUP, 1'b0, '0, 64'h0000_0000_0a09_0909, 8'd0, 8'd0);
        offer(OP_LOOKUP, 1'b0, '0, 64'h0000_0000_0b00_0000, 8'd0, 8'd0);
        // IPv6: a /32, a full-length host, a length past the limit and a default route held by peer zero.
        offer(OP_INSERT, 1'b1, 64'h2001_0db8_dead_beef, ones, 8'd32, 8'd4);
        offer(OP_INSERT, 1'b1, ones, ones, 8'd128, 8'd5);
        offer(OP_INSERT, 1'b1, ones, ones, 8'd129, 8'd5);
        offer(OP_INSERT, 1'b1, ones, ones, 8'd0, 8'd0);
        offer(OP_LOOKUP, 1'b1, '0, 64'h1, 8'd0, 8'd0);
        offer(OP_LOOKUP, 1'b1, ones, ones, 8'd0, 8'd0);
        offer(OP_LOOKUP, 1'b1, 64'h2001_0db8_0000_0001, 64'h1234, 8'd0, 8'd0);
        // Reinserting the /8 with host bits set must update the peer in place.
        offer(OP_INSERT, 1'b0, ones, 64'h0000_0000_0aff_0001, 8'd8, 8'd6);
        offer(OP_LOOKUP, 1'b0, '0, 64'h0000_0000_0a09_0909, 8'd0, 8'd0);
        offer(OP_NONE, 1'b1, ones, ones, 8'd255, 8'd255);
        offer(OP_REMOVE, 1'b0, '0, '0, 8'd0, 8'd0);
        offer(OP_LOOKUP, 1'b1, '0, 64'h1, 8'd0, 8'd0);
        offer(OP_REMOVE, 1'b1, ones, ones, 8'd0, 8'd6);
        offer(OP_LOOKUP, 1'b0, '0, 64'h0000_0000_0a09_0909, 8'd0, 8'd0);
        offer(OP_REMOVE, 1'b0, '0, '0, 8'd0, 8'd255);
        offer(OP_LOOKUP, 1'b0, '0, 64'h0000_0000_0a01_0203, 8'd0, 8'd0);

        for (int i = 0; i < 400; i++) begin
            if (i % 50 == 0) sender_steady = ($urandom_range(0, 2) == 0);
            random_request(i >= 220);
        end
        s_tvalid <= 1'b0;

        while (routes.owed_answers.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);

        $display("Sent %0d inserts kept, %0d too long, %0d refused on a full table;",
                 routes.stored, routes.too_long, routes.full);
        $display("%0d lookups with %0d hits, %0d peer removals, %0d result beats checked.",
                 routes.lookups, routes.hits, routes.removals, routes.checked);
        if (routes.errors == 0 && routes.owed_answers.size() == 0) begin
            $display("longest_prefix_match_table regression: pass");
        end else begin
            $display("longest_prefix_match_table regression: fail");
        end
        $finish;
    end

endmodule
